FILE: sv/hel_pkg.sv
// Shared types, constants and helpers for the hex encoder with line wrapping.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hel_pkg;

  localparam int unsigned COL_W   = 12;  // column counter and line length width
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SLOTS   = 4;   // most characters one request can produce
  localparam int unsigned CNT_W   = 3;   // holds 0..SLOTS
  localparam int unsigned IDX_W   = 2;   // indexes 0..SLOTS-1
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = COL_W;

  localparam logic [CHAR_W-1:0] NEWLINE = 8'h0A;

  // operation codes of an input request
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UPPERCASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 1'b1;

  // characters produced by one request, in emission order
  typedef struct packed {
    logic [SLOTS-1:0][CHAR_W-1:0] chars;
    logic [CNT_W-1:0]             cnt;
  } seq_t;

  // ASCII hex digit of a nibble
  function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib,
                                                   input logic       upper);
    logic [CHAR_W-1:0] base;
    base = upper ? 8'h41 : 8'h61;
    if (nib < 4'd10) begin
      hex_digit = 8'h30 + {4'h0, nib};
    end else begin
      hex_digit = base + {4'h0, nib} - 8'd10;
    end
  endfunction

endpackage

FILE: sv/hex_encoder_line_wrap.sv
// Hex encoder with line wrapping, top level: input register, column state,
// configuration registers, formatter and result buffer. Uses hel_pkg.
// Path: an accepted request waits in the input register until the result buffer
// can load its formatted sequence; the buffer then offers the first character.
// Throughput: one character per cycle while out_ready is high; a data byte yields
// 2 to 4 characters on the single-character output port, a flush at most one newline.
// Reset (synchronous, rst_n low): pipeline empty, column 0, uppercase 1, line length 0.
`timescale 1ns / 1ps

module hex_encoder_line_wrap (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hel_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hel_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [hel_pkg::BYTE_W-1:0]       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hel_pkg::CHAR_W-1:0]       out_character,
  output logic                             out_last
);
  import hel_pkg::*;

  logic              uppercase_r;
  logic [COL_W-1:0]  line_length_r;
  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  col_nxt;
  logic              s1_valid_r;
  logic              s1_op_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_move;
  logic              buf_ready;
  seq_t              seq;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uppercase_r   <= 1'b1;
      line_length_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UPPERCASE:   uppercase_r   <= cfg_data[0];
        CFG_LINE_LENGTH: line_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register handshake
  assign s1_move  = s1_valid_r && buf_ready;
  assign in_ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= in_operation;
      s1_byte_r <= in_data_byte;
    end
  end

  // formatter
  hel_format u_format (
    .op          (s1_op_r),
    .data_byte   (s1_byte_r),
    .col         (col_r),
    .line_length (line_length_r),
    .uppercase   (uppercase_r),
    .seq         (seq),
    .col_nxt     (col_nxt)
  );

  // column counter advances when a request leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (s1_move) begin
      col_r <= col_nxt;
    end
  end

  // result buffer
  hel_out_buf u_out_buf (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_valid    (s1_valid_r),
    .load_seq      (seq),
    .load_ready    (buf_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted request not held in input register");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_op_r)))
    else $error("stalled request lost or changed");
  a_col_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> $stable(col_r))
    else $error("column changed without a request");

endmodule

FILE: sv/hel_format.sv
// Single-pass formatter: turns one request and the current column into the
// character sequence it produces and the next column. Uses hel_pkg.
`timescale 1ns / 1ps

module hel_format (
  input  logic                      op,
  input  logic [hel_pkg::BYTE_W-1:0] data_byte,
  input  logic [hel_pkg::COL_W-1:0]  col,
  input  logic [hel_pkg::COL_W-1:0]  line_length,
  input  logic                      uppercase,
  output hel_pkg::seq_t             seq,
  output logic [hel_pkg::COL_W-1:0]  col_nxt
);
  import hel_pkg::*;

  logic              wrap_on;
  logic [CHAR_W-1:0] dig_hi;
  logic [CHAR_W-1:0] dig_lo;
  logic [COL_W-1:0]  col_a;
  logic [COL_W-1:0]  col_a_kept;
  logic [COL_W-1:0]  col_b;
  logic              nl_a;
  logic              nl_b;

  assign wrap_on = (line_length != '0);
  assign dig_hi  = hex_digit(data_byte[7:4], uppercase);
  assign dig_lo  = hex_digit(data_byte[3:0], uppercase);

  // column after each digit; counter wraps modulo 2^COL_W
  assign col_a      = col + COL_W'(1);
  assign nl_a       = wrap_on && (col_a == line_length);
  assign col_a_kept = nl_a ? '0 : col_a;
  assign col_b      = col_a_kept + COL_W'(1);
  assign nl_b       = wrap_on && (col_b == line_length);

  // assemble the sequence
  always_comb begin
    seq.chars = '{default: NEWLINE};
    seq.cnt   = '0;
    col_nxt   = col;
    if (op == OP_FLUSH) begin
      seq.cnt = (wrap_on && col != '0) ? CNT_W'(1) : CNT_W'(0);
      col_nxt = '0;
    end else begin
      seq.chars[0] = dig_hi;
      if (nl_a) begin
        seq.chars[2] = dig_lo;       // newline sits between the two digits
      end else begin
        seq.chars[1] = dig_lo;
      end
      seq.cnt = CNT_W'(2) + CNT_W'(nl_a) + CNT_W'(nl_b);
      if (wrap_on) begin
        col_nxt = nl_b ? '0 : col_b;
      end
    end
  end

endmodule

FILE: sv/hel_out_buf.sv
// Result buffer: holds one formatted sequence and streams it one character
// per cycle while out_ready is high, with a last flag. Uses hel_pkg.
`timescale 1ns / 1ps

module hel_out_buf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load_valid,
  input  hel_pkg::seq_t              load_seq,
  output logic                       load_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hel_pkg::CHAR_W-1:0] out_character,
  output logic                       out_last
);
  import hel_pkg::*;

  logic [SLOTS-1:0][CHAR_W-1:0] chars_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [IDX_W-1:0]             idx_r;
  logic                         valid_r;
  logic                         is_last;
  logic                         take;
  logic                         load;

  assign is_last       = ({1'b0, idx_r} == (cnt_r - CNT_W'(1)));
  assign take          = valid_r && out_ready;
  assign load_ready    = !valid_r || (take && is_last);
  assign load          = load_valid && load_ready;

  assign out_valid     = valid_r;
  assign out_character = chars_r[idx_r];
  assign out_last      = is_last;

  // control: valid flag and character index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else if (load) begin
      valid_r <= (load_seq.cnt != '0);
      idx_r   <= '0;
      cnt_r   <= load_seq.cnt;
    end else if (take) begin
      if (is_last) begin
        valid_r <= 1'b0;
      end
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      chars_r <= load_seq.chars;
    end
  end

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (cnt_r != '0))
    else $error("buffer holds a sequence of zero characters");
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ({1'b0, idx_r} < cnt_r))
    else $error("character index beyond sequence length");
  a_step_index: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !is_last && !load) |=> (idx_r == $past(idx_r) + IDX_W'(1)))
    else $error("index did not advance after a character was taken");

endmodule
